@@ hw/rtl/jdd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jdd_pkg
// Shared types, constants and tables for the joystick to differential drive
// pipeline.
// ----------------------------------------------------------------------------
package jdd_pkg;

  localparam int ADC_FULL_SCALE = 4095;
  localparam int SEND_LIMIT     = 99;
  localparam int DUTY_FULL      = 25600;
  localparam int DUTY_W         = 16;
  localparam int MAG_W          = 15;

  // 100 percent in Q8, squared, is 625 << 20.
  localparam int SQRT_SCALE     = 625;
  localparam int SQRT_SHIFT     = 20;
  localparam int SUMSQ_W        = 25;
  localparam int SCALED_W       = 35;
  localparam int ROOT_W         = 28;
  localparam int RAD_W          = 2 * ROOT_W;
  localparam int REM_W          = ROOT_W + 4;
  localparam int SQRT_LAT       = ROOT_W;

  localparam int DIVIDEND_W     = 28;
  localparam int DIVISOR_W      = 13;
  localparam int QUOT_BITS      = 16;
  localparam int DIV_LAT        = QUOT_BITS + 1;

  localparam int CORDIC_STEPS   = 16;
  localparam int CORDIC_W       = 32;
  localparam int ANGLE_W        = 18;
  localparam int RATIO_W        = 17;
  localparam int RATIO_ONE      = 65536;
  localparam int CORDIC_LAT     = CORDIC_STEPS + 1;

  typedef enum logic [1:0] {
    CFG_X_CENTER    = 2'd0,
    CFG_Y_CENTER    = 2'd1,
    CFG_DEAD_RADIUS = 2'd2,
    CFG_BACK_RADIUS = 2'd3
  } cfg_idx_e;

  // Sideband that travels beside the arithmetic units.
  typedef struct packed {
    logic                  valid;
    logic                  fwd;
    logic                  back_band;
    logic                  dead;
    logic                  xge;
    logic [11:0]           dx;
    logic [11:0]           dy;
    logic                  back_neg;
    logic [DIVIDEND_W-1:0] back_num;
    logic [DIVISOR_W-1:0]  back_den;
  } side_t;

  // Arctangent of 2^-i in quarter turns, Q16.
  function automatic logic [15:0] cordic_angle(input int i);
    logic [15:0] a;
    case (i)
      0:       a = 16'd32768;
      1:       a = 16'd19344;
      2:       a = 16'd10221;
      3:       a = 16'd5188;
      4:       a = 16'd2604;
      5:       a = 16'd1303;
      6:       a = 16'd652;
      7:       a = 16'd326;
      8:       a = 16'd163;
      9:       a = 16'd81;
      10:      a = 16'd41;
      11:      a = 16'd20;
      12:      a = 16'd10;
      13:      a = 16'd5;
      14:      a = 16'd3;
      15:      a = 16'd1;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/jdd_isqrt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jdd_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module jdd_isqrt
  import jdd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [SCALED_W-1:0] scaled,
  output logic      [ROOT_W-1:0]   root
);

  logic [RAD_W-1:0]  rad_r  [0:ROOT_W-1];
  logic [REM_W-1:0]  rem_r  [0:ROOT_W-1];
  logic [ROOT_W-1:0] root_r [0:ROOT_W-1];

  logic [RAD_W-1:0] rad_in;
  assign rad_in = RAD_W'({scaled, {SQRT_SHIFT{1'b0}}});

  for (genvar i = 0; i < ROOT_W; i++) begin : g_step
    logic [RAD_W-1:0]  rad_i;
    logic [REM_W-1:0]  rem_i, rem_s, trial, rem_nxt;
    logic [ROOT_W-1:0] root_i, root_nxt;
    logic [RAD_W-1:0]  rad_nxt;

    if (i == 0) begin : g_first
      assign rad_i  = rad_in;
      assign rem_i  = '0;
      assign root_i = '0;
    end else begin : g_rest
      assign rad_i  = rad_r[i-1];
      assign rem_i  = rem_r[i-1];
      assign root_i = root_r[i-1];
    end

    always_comb begin
      rem_s   = {rem_i[REM_W-3:0], rad_i[RAD_W-1 -: 2]};
      trial   = {2'b00, root_i, 2'b01};
      rad_nxt = {rad_i[RAD_W-3:0], 2'b00};
      if (rem_s >= trial) begin
        rem_nxt  = rem_s - trial;
        root_nxt = {root_i[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_s;
        root_nxt = {root_i[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[i]  <= rad_nxt;
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
      end
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule
`default_nettype wire

@@ hw/rtl/jdd_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jdd_div
// Pipelined restoring divider whose quotient saturates at full duty.
// ----------------------------------------------------------------------------
module jdd_div
  import jdd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic      [MAG_W-1:0]      quot
);

  localparam int CMP_W = DIVISOR_W + QUOT_BITS;

  logic [DIVIDEND_W-1:0] rem_r  [0:QUOT_BITS];
  logic [DIVISOR_W-1:0]  den_r  [0:QUOT_BITS];
  logic [QUOT_BITS-1:0]  q_r    [0:QUOT_BITS];
  logic                  sat_r  [0:QUOT_BITS];
  logic                  zero_r [0:QUOT_BITS];

  // The quotient cannot exceed its 16 bits unless the dividend reaches
  // the divisor shifted by 16; a zero divisor lands here as well.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= dividend;
      den_r[0]  <= divisor;
      q_r[0]    <= '0;
      zero_r[0] <= (dividend == '0);
      sat_r[0]  <= (CMP_W'(dividend) >= {divisor, {QUOT_BITS{1'b0}}});
    end
  end

  for (genvar k = 1; k <= QUOT_BITS; k++) begin : g_bit
    localparam int B = QUOT_BITS - k;
    logic [CMP_W-1:0]      shifted;
    logic                  take;
    logic [DIVIDEND_W-1:0] rem_nxt;

    always_comb begin
      shifted = CMP_W'(den_r[k-1]) << B;
      take    = CMP_W'(rem_r[k-1]) >= shifted;
      rem_nxt = take ? rem_r[k-1] - DIVIDEND_W'(shifted) : rem_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= den_r[k-1];
        q_r[k]    <= q_r[k-1] | (QUOT_BITS'(take) << B);
        sat_r[k]  <= sat_r[k-1];
        zero_r[k] <= zero_r[k-1];
      end
    end
  end

  always_comb begin
    if (zero_r[QUOT_BITS]) begin
      quot = '0;
    end else if (sat_r[QUOT_BITS] || (q_r[QUOT_BITS] > QUOT_BITS'(DUTY_FULL))) begin
      quot = MAG_W'(DUTY_FULL);
    end else begin
      quot = q_r[QUOT_BITS][MAG_W-1:0];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/jdd_cordic.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jdd_cordic
// Pipelined vectoring CORDIC giving atan(dy/dx) as a fraction of a quarter
// turn in Q16.
// ----------------------------------------------------------------------------
module jdd_cordic
  import jdd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [11:0]        dx,
  input  wire logic [11:0]        dy,
  output logic      [RATIO_W-1:0] ratio
);

  logic signed [CORDIC_W-1:0] cx_r  [0:CORDIC_STEPS-1];
  logic signed [CORDIC_W-1:0] cy_r  [0:CORDIC_STEPS-1];
  logic signed [ANGLE_W-1:0]  z_r   [0:CORDIC_STEPS-1];
  logic                       dxz_r [0:CORDIC_STEPS-1];
  logic                       dyz_r [0:CORDIC_STEPS-1];
  logic        [RATIO_W-1:0]  ratio_r;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic signed [CORDIC_W-1:0] cx_i, cy_i, cx_nxt, cy_nxt;
    logic signed [ANGLE_W-1:0]  z_i, z_nxt, ang;
    logic                       dxz_i, dyz_i;

    if (i == 0) begin : g_first
      assign cx_i  = $signed({4'b0, dx, 16'b0});
      assign cy_i  = $signed({4'b0, dy, 16'b0});
      assign z_i   = '0;
      assign dxz_i = (dx == '0);
      assign dyz_i = (dy == '0);
    end else begin : g_rest
      assign cx_i  = cx_r[i-1];
      assign cy_i  = cy_r[i-1];
      assign z_i   = z_r[i-1];
      assign dxz_i = dxz_r[i-1];
      assign dyz_i = dyz_r[i-1];
    end

    assign ang = $signed({2'b00, cordic_angle(i)});

    always_comb begin
      if (cy_i > 0) begin
        cx_nxt = cx_i + (cy_i >>> i);
        cy_nxt = cy_i - (cx_i >>> i);
        z_nxt  = z_i + ang;
      end else begin
        cx_nxt = cx_i - (cy_i >>> i);
        cy_nxt = cy_i + (cx_i >>> i);
        z_nxt  = z_i - ang;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cx_r[i]  <= cx_nxt;
        cy_r[i]  <= cy_nxt;
        z_r[i]   <= z_nxt;
        dxz_r[i] <= dxz_i;
        dyz_r[i] <= dyz_i;
      end
    end
  end

  logic signed [ANGLE_W-1:0] z_end;
  logic        [RATIO_W-1:0] ratio_nxt;
  assign z_end = z_r[CORDIC_STEPS-1];

  // A vertical stick is a full quarter turn and a horizontal one is none.
  always_comb begin
    if (dxz_r[CORDIC_STEPS-1]) begin
      ratio_nxt = RATIO_W'(RATIO_ONE);
    end else if (dyz_r[CORDIC_STEPS-1] || (z_end < 0)) begin
      ratio_nxt = '0;
    end else if (z_end > ANGLE_W'(RATIO_ONE)) begin
      ratio_nxt = RATIO_W'(RATIO_ONE);
    end else begin
      ratio_nxt = z_end[RATIO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ratio_r <= ratio_nxt;
    end
  end

  assign ratio = ratio_r;

endmodule
`default_nettype wire

@@ hw/rtl/joystick_to_differential_drive.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// joystick_to_differential_drive
// Turns a joystick sample pair into left and right wheel duties.
// ----------------------------------------------------------------------------
// A sample pair arrives on the in_ channel and one result per pair leaves on
// the out_ channel, both valid/ready; a transfer takes place when valid and
// ready are high together. The pipeline accepts one pair every cycle while
// the output is not stalled. From an input transfer to the result becoming
// valid a pair passes four front stages (offsets, squares, sum, scaling), 28
// square root stages, 17 stages in which the divider and the CORDIC run side
// by side, one multiply stage and the output register.
// The whole pipeline moves together: while a result waits at the output and
// out_ready is low, every stage holds and in_ready is low, so nothing is lost
// or repeated. Once the output is taken the pipeline moves again at once.
// The cfg_ port writes the centre and radius registers; write it only while
// no transfer is in flight. Reset clears every valid bit and restores the
// register defaults; the block accepts input in the first cycle after reset.
// ----------------------------------------------------------------------------
module joystick_to_differential_drive
  import jdd_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [11:0]              cfg_wdata,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [11:0]              in_joy_x,
  input  wire logic [11:0]              in_joy_y,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DUTY_W-1:0]      out_left_duty,
  output logic signed [DUTY_W-1:0]      out_right_duty,
  output logic signed [7:0]             out_left_send,
  output logic signed [7:0]             out_right_send,
  output logic                          out_left_reverse,
  output logic                          out_right_reverse
);

  logic [11:0] x_center_r, y_center_r;
  logic [10:0] dead_radius_r, back_radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_center_r    <= 12'd1917;
      y_center_r    <= 12'd1955;
      dead_radius_r <= 11'd5;
      back_radius_r <= 11'd40;
    end else if (cfg_we) begin
      case (cfg_idx_e'(cfg_index))
        CFG_X_CENTER:    x_center_r    <= cfg_wdata;
        CFG_Y_CENTER:    y_center_r    <= cfg_wdata;
        CFG_DEAD_RADIUS: dead_radius_r <= cfg_wdata[10:0];
        CFG_BACK_RADIUS: back_radius_r <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Front stage 1: offsets, region tests and the reverse scale operands.
  logic signed [14:0] xs, ys, xc, yc, dr, br, num, den;
  logic [14:0]        num_abs, den_abs;
  side_t              s1_nxt, s2_nxt, s1_r, s2_r, s3_r, s4_r;

  always_comb begin
    xs = $signed({3'b0, in_joy_x});
    ys = $signed({3'b0, in_joy_y});
    xc = $signed({3'b0, x_center_r});
    yc = $signed({3'b0, y_center_r});
    dr = $signed({4'b0, dead_radius_r});
    br = $signed({4'b0, back_radius_r});
    num = ys - yc - dr;
    den = 15'(ADC_FULL_SCALE) - yc - dr;
    num_abs = num[14] ? 15'(-num) : 15'(num);
    den_abs = den[14] ? 15'(-den) : 15'(den);

    s1_nxt.valid     = in_valid;
    s1_nxt.fwd       = (in_joy_y <= y_center_r);
    s1_nxt.back_band = (xs > xc - br) && (xs < xc + br) && (ys > yc + br);
    s1_nxt.dead      = (xs > xc - dr) && (xs < xc + dr) && (ys > yc - dr) && (ys < yc + dr);
    s1_nxt.xge       = (in_joy_x >= x_center_r);
    s1_nxt.dx        = s1_nxt.xge ? in_joy_x - x_center_r : x_center_r - in_joy_x;
    s1_nxt.dy        = y_center_r - in_joy_y;
    s1_nxt.back_neg  = num[14] ^ den[14];
    s1_nxt.back_num  = DIVIDEND_W'(num_abs);
    s1_nxt.back_den  = den_abs[DIVISOR_W-1:0];
  end

  // Stage 2 scales the reverse numerator to full duty.
  always_comb begin
    s2_nxt          = s1_r;
    s2_nxt.back_num = s1_r.back_num * DIVIDEND_W'(DUTY_FULL);
  end

  logic [23:0]         dxsq2_r, dysq2_r;
  logic [SUMSQ_W-1:0]  sumsq3_r;
  logic [SCALED_W-1:0] scaled4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
      s4_r.valid <= 1'b0;
    end else if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s2_r;
      s4_r <= s3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dxsq2_r   <= 24'(s1_r.dx) * 24'(s1_r.dx);
      dysq2_r   <= 24'(s1_r.dy) * 24'(s1_r.dy);
      sumsq3_r  <= SUMSQ_W'(dxsq2_r) + SUMSQ_W'(dysq2_r);
      scaled4_r <= SCALED_W'(sumsq3_r) * SCALED_W'(SQRT_SCALE);
    end
  end

  // Square root of the scaled sum of squares.
  logic [ROOT_W-1:0] root;
  side_t             sa_r [1:SQRT_LAT];

  jdd_isqrt u_isqrt (
    .clk    (clk),
    .en     (adv),
    .scaled (scaled4_r),
    .root   (root)
  );

  for (genvar i = 1; i <= SQRT_LAT; i++) begin : g_side_a
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sa_r[i].valid <= 1'b0;
      end else if (adv) begin
        sa_r[i] <= (i == 1) ? s4_r : sa_r[(i == 1) ? 1 : i-1];
      end
    end
  end

  // Magnitude and reverse divisions beside the CORDIC.
  side_t              sb_r [1:DIV_LAT];
  side_t              sm;
  logic [MAG_W-1:0]   mag_q, back_q;
  logic [RATIO_W-1:0] ratio;
  side_t              sq;

  assign sq = sa_r[SQRT_LAT];

  jdd_div u_mag_div (
    .clk      (clk),
    .en       (adv),
    .dividend (root),
    .divisor  (DIVISOR_W'(y_center_r)),
    .quot     (mag_q)
  );

  jdd_div u_back_div (
    .clk      (clk),
    .en       (adv),
    .dividend (sq.back_num),
    .divisor  (sq.back_den),
    .quot     (back_q)
  );

  jdd_cordic u_cordic (
    .clk   (clk),
    .en    (adv),
    .dx    (sq.dx),
    .dy    (sq.dy),
    .ratio (ratio)
  );

  for (genvar i = 1; i <= DIV_LAT; i++) begin : g_side_b
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sb_r[i].valid <= 1'b0;
      end else if (adv) begin
        sb_r[i] <= (i == 1) ? sq : sb_r[(i == 1) ? 1 : i-1];
      end
    end
  end

  assign sm = sb_r[DIV_LAT];

  // Multiply stage.
  side_t                     s50_r;
  logic [MAG_W-1:0]          mag50_r;
  logic [MAG_W+RATIO_W-1:0]  prod50_r;
  logic signed [DUTY_W-1:0]  back50_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s50_r.valid <= 1'b0;
    end else if (adv) begin
      s50_r <= sm;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag50_r  <= mag_q;
      prod50_r <= (MAG_W+RATIO_W)'(mag_q) * (MAG_W+RATIO_W)'(ratio);
      back50_r <= sm.back_neg ? $signed({1'b0, back_q}) : -$signed({1'b0, back_q});
    end
  end

  // Wheel selection and send values.
  function automatic logic [8:0] send_of(input logic signed [DUTY_W-1:0] duty);
    logic [DUTY_W-1:0] mag;
    logic [7:0]        t, s;
    logic              neg;
    neg = duty[DUTY_W-1];
    mag = neg ? DUTY_W'(-duty) : DUTY_W'(duty);
    t   = mag[15:8];
    s   = (t > 8'(SEND_LIMIT)) ? 8'(SEND_LIMIT) : t;
    // Upper eight bits are the send value and the low bit the reverse flag.
    return {neg ? 8'(-s) : s, neg || (t == 8'd0)};
  endfunction

  logic signed [DUTY_W-1:0] left_nxt, right_nxt, other;
  logic [8:0]               left_emit, right_emit;

  always_comb begin
    other = $signed(prod50_r[31:16]);
    if (s50_r.dead) begin
      left_nxt  = '0;
      right_nxt = '0;
    end else if (s50_r.fwd) begin
      if (s50_r.xge) begin
        left_nxt  = $signed({1'b0, mag50_r});
        right_nxt = other;
      end else begin
        left_nxt  = other;
        right_nxt = $signed({1'b0, mag50_r});
      end
    end else if (s50_r.back_band) begin
      left_nxt  = back50_r;
      right_nxt = back50_r;
    end else begin
      left_nxt  = '0;
      right_nxt = '0;
    end
    left_emit  = send_of(left_nxt);
    right_emit = send_of(right_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s50_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_left_duty     <= left_nxt;
      out_right_duty    <= right_nxt;
      out_left_send     <= $signed(left_emit[8:1]);
      out_right_send    <= $signed(right_emit[8:1]);
      out_left_reverse  <= left_emit[0];
      out_right_reverse <= right_emit[0];
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(sm) && $stable(s50_r))
    else $error("pipeline moved while the output was stalled");

  a_send_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_left_send <= 8'sd99) && (out_left_send >= -8'sd99) &&
                    (out_right_send <= 8'sd99) && (out_right_send >= -8'sd99))
    else $error("send value beyond limit");

  a_reverse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_left_reverse == (out_left_duty < 16'sd256)) &&
                    (out_right_reverse == (out_right_duty < 16'sd256)))
    else $error("reverse flag disagrees with duty");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output valid after reset");
`endif

endmodule
`default_nettype wire
